// ----- rtl/pdfm_pkg.sv -----
// Package for the pulse duty and frequency meter.
// Holds field widths, register defaults, register indexes and the queue entry type.
// No dependencies.
`timescale 1ns / 1ps

package pdfm_pkg;

	localparam int CAPTURE_W   = 16;
	localparam int SCALE_W     = 7;
	localparam int NUM_W       = 24;
	localparam int PERIOD_W    = 22;
	localparam int SUM_W       = PERIOD_W + 1;
	localparam int DUTY_W      = 7;
	localparam int PROD_W      = CAPTURE_W + SCALE_W;
	localparam int DIVIDEND_W  = PERIOD_W + 7;
	localparam int DIV_STEPS   = DIVIDEND_W;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 80;
	localparam int CFG_DATA_W  = NUM_W;
	localparam int CFG_IDX_W   = 2;

	localparam logic [PERIOD_W-1:0]   PERIOD_MAX      = {PERIOD_W{1'b1}};
	localparam logic [DIVIDEND_W-1:0] PERCENT         = DIVIDEND_W'(100);
	localparam logic [SCALE_W-1:0]    SCALE_RESET     = SCALE_W'(4);
	localparam logic [NUM_W-1:0]      NUMERATOR_RESET = NUM_W'(1000000);
	localparam logic                  EDGE_RESET      = 1'b0;

	localparam int QUEUE_DEPTH_DEF = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STARTING_EDGE  = 2'd0,
		CFG_TICK_SCALE     = 2'd1,
		CFG_FREQ_NUMERATOR = 2'd2
	} cfg_idx_t;

	// One measured event handed from the front to the back.
	typedef struct packed {
		logic [PERIOD_W-1:0] high;
		logic [PERIOD_W-1:0] low;
		logic                next_falling;
	} pdfm_entry_t;

	// Reload of the awaited edge polarity from a configuration write.
	typedef struct packed {
		logic load;
		logic value;
	} pdfm_edge_load_t;

endpackage

// ----- rtl/pdfm_front.sv -----
// Front end of the meter: accepts capture timestamps, tracks the awaited edge
// and produces the scaled high and low periods. Depends on pdfm_pkg.
`timescale 1ns / 1ps

module pdfm_front
	import pdfm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 capture_valid,
	output logic                 capture_ready,
	input  logic [CAPTURE_W-1:0] capture_time,
	input  logic [SCALE_W-1:0]   tick_scale,
	input  pdfm_edge_load_t      edge_load,
	input  logic                 q_full,
	output logic                 push,
	output pdfm_entry_t          push_data
);

	logic                 expect_falling_q;
	logic [CAPTURE_W-1:0] last_capture_q;
	logic [PERIOD_W-1:0]  high_q;
	logic [PERIOD_W-1:0]  low_q;
	logic [CAPTURE_W-1:0] delta;
	logic [PROD_W-1:0]    prod;
	logic [PERIOD_W-1:0]  period;

	assign capture_ready = !q_full;
	assign push          = capture_valid && capture_ready;

	// The counter difference wraps naturally at the capture width.
	assign delta  = capture_time - last_capture_q;
	assign prod   = PROD_W'(delta) * PROD_W'(tick_scale);
	assign period = (prod > PROD_W'(PERIOD_MAX)) ? PERIOD_MAX : prod[PERIOD_W-1:0];

	always_comb begin
		push_data.high         = expect_falling_q ? period : high_q;
		push_data.low          = expect_falling_q ? low_q : period;
		push_data.next_falling = !expect_falling_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_falling_q <= EDGE_RESET;
			last_capture_q   <= '0;
			high_q           <= '0;
			low_q            <= '0;
		end else if (edge_load.load) begin
			expect_falling_q <= edge_load.value;
		end else if (push) begin
			expect_falling_q <= !expect_falling_q;
			last_capture_q   <= capture_time;
			high_q           <= push_data.high;
			low_q            <= push_data.low;
		end
	end

endmodule

// ----- rtl/pdfm_queue.sv -----
// Short register queue between the front end and the divider back end.
// Depends on pdfm_pkg for the entry type.
`timescale 1ns / 1ps

module pdfm_queue
	import pdfm_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  pdfm_entry_t push_data,
	input  logic        pop,
	output pdfm_entry_t pop_data,
	output logic        full,
	output logic        empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pdfm_entry_t      mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/pdfm_back.sv -----
// Back end of the meter: computes duty and frequency with a shared-step
// restoring divider and holds the result in an output register. Depends on pdfm_pkg.
`timescale 1ns / 1ps

module pdfm_back
	import pdfm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	input  pdfm_entry_t            q_data,
	output logic                   pop,
	input  logic [NUM_W-1:0]       freq_numerator,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_TDATA_W-1:0] out_data,
	output logic                   out_invalid
);

	localparam int STEP_W = $clog2(DIV_STEPS);
	localparam int PAD_W  = OUT_TDATA_W - 2 * PERIOD_W - DUTY_W - NUM_W - 1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t                  state_q;
	pdfm_entry_t             ent_q;
	logic [SUM_W-1:0]        sum_q;
	logic [DIVIDEND_W-1:0]   duty_dq_q;
	logic [DIVIDEND_W-1:0]   freq_dq_q;
	logic [SUM_W-1:0]        duty_rem_q;
	logic [SUM_W-1:0]        freq_rem_q;
	logic [STEP_W-1:0]       step_q;
	logic                    invalid_q;
	logic                    out_valid_q;
	logic [OUT_TDATA_W-1:0]  out_data_q;
	logic                    out_invalid_q;

	logic [SUM_W-1:0]        sum;
	logic [SUM_W:0]          duty_trial;
	logic [SUM_W:0]          freq_trial;
	logic                    duty_ge;
	logic                    freq_ge;
	logic                    out_load;

	assign sum = SUM_W'(ent_q.high) + SUM_W'(ent_q.low);

	// Both quotients are built in lock step against the same divisor.
	assign duty_trial = {duty_rem_q, duty_dq_q[DIVIDEND_W-1]};
	assign freq_trial = {freq_rem_q, freq_dq_q[DIVIDEND_W-1]};
	assign duty_ge    = duty_trial >= {1'b0, sum_q};
	assign freq_ge    = freq_trial >= {1'b0, sum_q};

	assign pop      = (state_q == ST_IDLE) && !q_empty;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	assign out_valid   = out_valid_q;
	assign out_data    = out_data_q;
	assign out_invalid = out_invalid_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					ent_q <= q_data;
				end
			end
			ST_LOAD: begin
				sum_q      <= sum;
				duty_rem_q <= '0;
				freq_rem_q <= '0;
				step_q     <= '0;
				invalid_q  <= (sum == '0);
				if (sum == '0) begin
					duty_dq_q <= '0;
					freq_dq_q <= '0;
				end else begin
					duty_dq_q <= DIVIDEND_W'(ent_q.high) * PERCENT;
					freq_dq_q <= DIVIDEND_W'(freq_numerator);
				end
			end
			ST_DIV: begin
				step_q     <= step_q + 1'b1;
				duty_rem_q <= duty_ge ? SUM_W'(duty_trial - {1'b0, sum_q})
					: duty_trial[SUM_W-1:0];
				freq_rem_q <= freq_ge ? SUM_W'(freq_trial - {1'b0, sum_q})
					: freq_trial[SUM_W-1:0];
				duty_dq_q  <= {duty_dq_q[DIVIDEND_W-2:0], duty_ge};
				freq_dq_q  <= {freq_dq_q[DIVIDEND_W-2:0], freq_ge};
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_data_q    <= {PAD_W'(0), ent_q.next_falling, freq_dq_q[NUM_W-1:0],
				duty_dq_q[DUTY_W-1:0], ent_q.low, ent_q.high};
			out_invalid_q <= invalid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= (sum == '0) ? ST_OUT : ST_DIV;
				end
				ST_DIV: begin
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/pulse_duty_frequency_meter.sv -----
// Top level of the pulse duty and frequency meter: configuration registers,
// front end, queue and divider back end. Depends on pdfm_pkg and the pdfm_* modules.
//
// Channel        Direction  Signals                          Content
// capture in     slave      s_axis_tvalid/tready/tdata[15:0] capture_time
// result out     master     m_axis_tvalid/tready/tdata[79:0] periods, duty, frequency, edge
//                           m_axis_tuser                     period_invalid
// configuration  write      cfg_we/cfg_index/cfg_data        starting_edge, tick_scale,
//                                                            freq_numerator
//
// Each event passes through the back end in order: pick-up from the queue, forming the sum
// and the percent product, 29 divider steps (skipped when the sum is zero), output load.
// The front end accepts a capture whenever the queue has room.
// Reset is asynchronous, returns all control state to its reset values and clears the front end's measurement state.
// A stalled output holds the back end; the front keeps accepting until the queue fills.
`timescale 1ns / 1ps

module pulse_duty_frequency_meter
	import pdfm_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [15:0] capture_time
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [21:0] on_period, [43:22] off_period, [50:44] duty_percent,
	// [74:51] frequency_hz, [75] next_edge_falling, [79:76] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                   m_axis_tuser,  // [0] period_invalid
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [SCALE_W-1:0] tick_scale_q;
	logic [NUM_W-1:0]   freq_numerator_q;
	pdfm_edge_load_t    edge_load;
	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_empty;
	pdfm_entry_t        q_push_data;
	pdfm_entry_t        q_pop_data;

	always_comb begin
		edge_load.load  = cfg_we && (cfg_index == CFG_STARTING_EDGE);
		edge_load.value = cfg_data[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_scale_q     <= SCALE_RESET;
			freq_numerator_q <= NUMERATOR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TICK_SCALE:     tick_scale_q     <= cfg_data[SCALE_W-1:0];
				CFG_FREQ_NUMERATOR: freq_numerator_q <= cfg_data[NUM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pdfm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.capture_valid (s_axis_tvalid),
		.capture_ready (s_axis_tready),
		.capture_time  (s_axis_tdata[CAPTURE_W-1:0]),
		.tick_scale    (tick_scale_q),
		.edge_load     (edge_load),
		.q_full        (q_full),
		.push          (q_push),
		.push_data     (q_push_data)
	);

	pdfm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	pdfm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_data         (q_pop_data),
		.pop            (q_pop),
		.freq_numerator (freq_numerator_q),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_data       (m_axis_tdata),
		.out_invalid    (m_axis_tuser)
	);

`ifndef ASSERT_OFF
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("capture transaction taken with the queue full");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("back end popped an empty queue");

	a_invalid_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[74:44] == '0))
		else $error("invalid period with nonzero duty or frequency");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[50:44] <= 7'd100))
		else $error("duty above one hundred percent");
`endif

endmodule
